// ----- rtl/pfre_pkg.sv -----
// Shared types, constants and request codes of the palette fade and rotate engine.
`timescale 1ns / 1ps

package pfre_pkg;

   localparam int ENTRIES    = 256;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CHAN_W     = 6;
   localparam int NUM_CHANS  = 3;
   localparam int COLOR_W    = CHAN_W * NUM_CHANS;
   localparam int FRAC_BITS  = 5;
   localparam int OUT_SHIFT  = 2;
   localparam int OUT_W      = CHAN_W + OUT_SHIFT;
   localparam int REQ_W      = 3;
   localparam int AMT_W      = 6;

   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(ENTRIES - 1);
   localparam logic [CHAN_W-1:0] CHAN_MAX   = {CHAN_W{1'b1}};
   localparam logic [AMT_W-1:0]  AMT_UNITY  = AMT_W'(1 << FRAC_BITS);

   localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_READ   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_FADE   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_LIGHT  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_ROTATE = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

   typedef enum logic {
      MAP_FADE,
      MAP_LIGHT
   } map_mode_type;

   typedef struct packed {
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [COLOR_W-1:0] wr_data;
   } ram_ctrl_type;

endpackage

// ----- rtl/pfre_color_unit.sv -----
// Shared per-entry color arithmetic: fade toward black or light up toward white.
`timescale 1ns / 1ps

module pfre_color_unit (
   input  pfre_pkg::map_mode_type                 mode,
   input  logic [pfre_pkg::AMT_W-1:0]             amount,
   input  logic [pfre_pkg::COLOR_W-1:0]           color_in,
   output logic [pfre_pkg::COLOR_W-1:0]           color_out
);

   for (genvar ch = 0; ch < pfre_pkg::NUM_CHANS; ch++) begin : g_chan
      logic [pfre_pkg::CHAN_W-1:0]   x;
      logic [pfre_pkg::CHAN_W-1:0]   mul_a;
      logic [2*pfre_pkg::CHAN_W-1:0] prod;
      logic [2*pfre_pkg::CHAN_W:0]   sum;
      logic [pfre_pkg::CHAN_W-1:0]   res;

      assign x     = color_in[ch*pfre_pkg::CHAN_W +: pfre_pkg::CHAN_W];
      assign mul_a = (mode == pfre_pkg::MAP_FADE) ? x : pfre_pkg::CHAN_MAX - x;
      assign prod  = mul_a * amount;
      assign sum   = {2'b00, x, {pfre_pkg::FRAC_BITS{1'b0}}} + {1'b0, prod};

      always_comb begin
         if (mode == pfre_pkg::MAP_FADE) begin
            res = prod[pfre_pkg::CHAN_W+pfre_pkg::FRAC_BITS-1:pfre_pkg::FRAC_BITS];
         end else if (sum[2*pfre_pkg::CHAN_W:pfre_pkg::CHAN_W+pfre_pkg::FRAC_BITS] != '0) begin
            res = pfre_pkg::CHAN_MAX;
         end else begin
            res = sum[pfre_pkg::CHAN_W+pfre_pkg::FRAC_BITS-1:pfre_pkg::FRAC_BITS];
         end
      end

      assign color_out[ch*pfre_pkg::CHAN_W +: pfre_pkg::CHAN_W] = res;
   end

endmodule

// ----- rtl/pfre_palette_ram.sv -----
// Palette storage: one write port and one registered read port.
`timescale 1ns / 1ps

module pfre_palette_ram (
   input  logic                          clock,
   input  pfre_pkg::ram_ctrl_type        ctrl,
   output logic [pfre_pkg::COLOR_W-1:0]  rd_data
);

   logic [pfre_pkg::COLOR_W-1:0] mem_ff [pfre_pkg::ENTRIES];
   logic [pfre_pkg::COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/palette_fade_rotate_engine_core.sv -----
// Top level of the palette fade and rotate engine: request sequencer and result register.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_type, req_entry_index, req_last_index,
//                                             req_red_in, req_green_in, req_blue_in, req_amount
//   rsp      out        rsp_valid/rsp_stall   rsp_red_out, rsp_green_out, rsp_blue_out
//
// A write goes straight into the RAM; a read is registered by the RAM, then by the
// result register once that is free. Fade and light-up (not a fade of 32 or more)
// and clear sweep one entry per cycle, clear through the write port alone. Rotate
// shifts first..last up by one, last wrapping to first, when first is below last.
// Reset clears the sequencer and the result valid; palette contents stay undefined.
// A stalled result holds; other requests are still taken, a read then waits behind it.
`timescale 1ns / 1ps

module palette_fade_rotate_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pfre_pkg::REQ_W-1:0]        req_type,
   input  logic [pfre_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [pfre_pkg::IDX_W-1:0]        req_last_index,
   input  logic [7:0]                        req_red_in,
   input  logic [7:0]                        req_green_in,
   input  logic [7:0]                        req_blue_in,
   input  logic [pfre_pkg::AMT_W-1:0]        req_amount,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pfre_pkg::OUT_W-1:0]        rsp_red_out,
   output logic [pfre_pkg::OUT_W-1:0]        rsp_green_out,
   output logic [pfre_pkg::OUT_W-1:0]        rsp_blue_out
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RESPOND,
      S_MAP,
      S_ROT_HOLD,
      S_ROT_WR,
      S_ROT_LAST,
      S_CLEAR
   } state_type;

   localparam int CW = pfre_pkg::CHAN_W;

   state_type                     state_ff, state_in;
   logic [pfre_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [pfre_pkg::IDX_W-1:0]    first_ff, first_in;
   pfre_pkg::map_mode_type        mode_ff, mode_in;
   logic [pfre_pkg::AMT_W-1:0]    amount_ff, amount_in;
   logic [pfre_pkg::COLOR_W-1:0]  held_ff, held_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pfre_pkg::OUT_W-1:0]    rsp_red_ff, rsp_red_in;
   logic [pfre_pkg::OUT_W-1:0]    rsp_green_ff, rsp_green_in;
   logic [pfre_pkg::OUT_W-1:0]    rsp_blue_ff, rsp_blue_in;

   logic                          accept;
   pfre_pkg::ram_ctrl_type        ram_ctrl;
   logic [pfre_pkg::COLOR_W-1:0]  rd_data;
   logic [pfre_pkg::COLOR_W-1:0]  mapped;
   logic [pfre_pkg::IDX_W-1:0]    idx_dec;

   pfre_palette_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (rd_data)
   );

   pfre_color_unit u_color (
      .mode      (mode_ff),
      .amount    (amount_ff),
      .color_in  (rd_data),
      .color_out (mapped)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_dec   = idx_ff - pfre_pkg::IDX_W'(1);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      first_in     = first_ff;
      mode_in      = mode_ff;
      amount_in    = amount_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      ram_ctrl     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type) inside
                  pfre_pkg::REQ_WRITE: begin
                     ram_ctrl.wr_en   = 1'b1;
                     ram_ctrl.wr_addr = req_entry_index;
                     ram_ctrl.wr_data = {req_red_in[CW-1:0], req_green_in[CW-1:0],
                                         req_blue_in[CW-1:0]};
                  end
                  pfre_pkg::REQ_READ: begin
                     ram_ctrl.rd_en   = 1'b1;
                     ram_ctrl.rd_addr = req_entry_index;
                     state_in         = S_RESPOND;
                  end
                  pfre_pkg::REQ_FADE, pfre_pkg::REQ_LIGHT: begin
                     if (req_type == pfre_pkg::REQ_LIGHT ||
                         req_amount < pfre_pkg::AMT_UNITY) begin
                        mode_in          = (req_type == pfre_pkg::REQ_LIGHT) ?
                                           pfre_pkg::MAP_LIGHT : pfre_pkg::MAP_FADE;
                        amount_in        = req_amount;
                        idx_in           = '0;
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = '0;
                        state_in         = S_MAP;
                     end
                  end
                  pfre_pkg::REQ_ROTATE: begin
                     first_in         = req_entry_index;
                     idx_in           = req_last_index;
                     ram_ctrl.rd_en   = 1'b1;
                     ram_ctrl.rd_addr = req_last_index;
                     state_in         = S_ROT_HOLD;
                  end
                  pfre_pkg::REQ_CLEAR: begin
                     idx_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = {rd_data[3*CW-1:2*CW], {pfre_pkg::OUT_SHIFT{1'b0}}};
               rsp_green_in = {rd_data[2*CW-1:CW], {pfre_pkg::OUT_SHIFT{1'b0}}};
               rsp_blue_in  = {rd_data[CW-1:0], {pfre_pkg::OUT_SHIFT{1'b0}}};
               state_in     = S_IDLE;
            end
         end
         S_MAP: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = idx_ff;
            ram_ctrl.wr_data = mapped;
            if (idx_ff == pfre_pkg::LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in           = idx_ff + pfre_pkg::IDX_W'(1);
               ram_ctrl.rd_en   = 1'b1;
               ram_ctrl.rd_addr = idx_ff + pfre_pkg::IDX_W'(1);
            end
         end
         S_ROT_HOLD: begin
            held_in = rd_data;
            if (idx_ff > first_ff) begin
               ram_ctrl.rd_en   = 1'b1;
               ram_ctrl.rd_addr = idx_dec;
               state_in         = S_ROT_WR;
            end else begin
               state_in = S_ROT_LAST;
            end
         end
         S_ROT_WR: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = idx_ff;
            ram_ctrl.wr_data = rd_data;
            idx_in           = idx_dec;
            if (idx_dec > first_ff) begin
               ram_ctrl.rd_en   = 1'b1;
               ram_ctrl.rd_addr = idx_dec - pfre_pkg::IDX_W'(1);
            end else begin
               state_in = S_ROT_LAST;
            end
         end
         S_ROT_LAST: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = first_ff;
            ram_ctrl.wr_data = held_ff;
            state_in         = S_IDLE;
         end
         S_CLEAR: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = idx_ff;
            ram_ctrl.wr_data = '0;
            if (idx_ff == pfre_pkg::LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + pfre_pkg::IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         first_ff     <= first_in;
         mode_ff      <= mode_in;
         amount_ff    <= amount_in;
         held_ff      <= held_in;
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;

`ifndef SYNTHESIS
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESPOND))
      else $error("result raised without a read");

   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      (ram_ctrl.rd_en && ram_ctrl.wr_en) |-> (ram_ctrl.rd_addr != ram_ctrl.wr_addr))
      else $error("read and write hit the same entry");

   a_map_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAP && idx_ff != pfre_pkg::LAST_IDX) |=>
      (state_ff == S_MAP && idx_ff == $past(idx_ff) + pfre_pkg::IDX_W'(1)))
      else $error("sweep skipped an entry");

   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT_WR) |-> (idx_ff > first_ff))
      else $error("rotate moved an entry outside its range");
`endif

endmodule

// ----- verif/palette_fade_rotate_engine_core_tb.sv -----
// Self-checking testbench for the palette fade and rotate engine: shadow palette and read checks.
`timescale 1ns / 1ps

module palette_fade_rotate_engine_core_tb;

   localparam logic [pfre_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [pfre_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;
   localparam int RANDOM_REQUESTS = 500;
   localparam int TAIL_CYCLES     = 300;
   localparam int STUCK_LIMIT     = 5000;

   typedef struct packed {
      logic [pfre_pkg::REQ_W-1:0]  kind;
      logic [pfre_pkg::IDX_W-1:0]  first;
      logic [pfre_pkg::IDX_W-1:0]  last;
      logic [7:0]                  red;
      logic [7:0]                  green;
      logic [7:0]                  blue;
      logic [pfre_pkg::AMT_W-1:0]  amt;
      logic [1:0]                  phase;
      logic                        drain;
   } palette_request_type;

   typedef struct packed {
      logic [pfre_pkg::OUT_W-1:0] red;
      logic [pfre_pkg::OUT_W-1:0] green;
      logic [pfre_pkg::OUT_W-1:0] blue;
   } scaled_color_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [pfre_pkg::OUT_W-1:0] rsp_red_out;
   logic [pfre_pkg::OUT_W-1:0] rsp_green_out;
   logic [pfre_pkg::OUT_W-1:0] rsp_blue_out;

   palette_request_type live_req = '0;
   logic [1:0]          drive_phase = 2'd0;

   palette_request_type          pending_requests [$];
   scaled_color_type             expected_colors [$];
   logic [pfre_pkg::COLOR_W-1:0] shadow_palette [pfre_pkg::ENTRIES];
   logic [pfre_pkg::IDX_W-1:0]   hot_indices [$];
   int                           fail_count = 0;
   int                           stuck_cycles = 0;
   logic [1:0]                   build_phase = 2'd0;
   logic                         build_drain = 1'b0;

   palette_fade_rotate_engine_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (live_req.kind),
      .req_entry_index (live_req.first),
      .req_last_index  (live_req.last),
      .req_red_in      (live_req.red),
      .req_green_in    (live_req.green),
      .req_blue_in     (live_req.blue),
      .req_amount      (live_req.amt),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int send_idle_pct(input logic [1:0] phase);
      case (phase)
         2'd0:    return 18;
         2'd1:    return 88;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(input logic [1:0] phase);
      case (phase)
         2'd0:    return 88;
         2'd1:    return 18;
         default: return 0;
      endcase
   endfunction

   // Apply one accepted request to the shadow palette; queue the scaled color of a read.
   function automatic void apply_palette_request(input palette_request_type rq);
      logic [pfre_pkg::COLOR_W-1:0] held;
      scaled_color_type             shade;
      int                           v;
      int                           a;
      int                           s;
      a = int'(rq.amt);
      case (rq.kind) inside
         pfre_pkg::REQ_WRITE: begin
            shadow_palette[rq.first] = {rq.red[pfre_pkg::CHAN_W-1:0],
                                        rq.green[pfre_pkg::CHAN_W-1:0],
                                        rq.blue[pfre_pkg::CHAN_W-1:0]};
         end
         pfre_pkg::REQ_READ: begin
            held = shadow_palette[rq.first];
            shade.red   = {held[3*pfre_pkg::CHAN_W-1:2*pfre_pkg::CHAN_W],
                           {pfre_pkg::OUT_SHIFT{1'b0}}};
            shade.green = {held[2*pfre_pkg::CHAN_W-1:pfre_pkg::CHAN_W],
                           {pfre_pkg::OUT_SHIFT{1'b0}}};
            shade.blue  = {held[pfre_pkg::CHAN_W-1:0], {pfre_pkg::OUT_SHIFT{1'b0}}};
            expected_colors.push_back(shade);
         end
         pfre_pkg::REQ_FADE, pfre_pkg::REQ_LIGHT: begin
            if (rq.kind == pfre_pkg::REQ_LIGHT || rq.amt < pfre_pkg::AMT_UNITY) begin
               for (int e = 0; e < pfre_pkg::ENTRIES; e++) begin
                  for (int c = 0; c < pfre_pkg::NUM_CHANS; c++) begin
                     v = int'(shadow_palette[e][c*pfre_pkg::CHAN_W +: pfre_pkg::CHAN_W]);
                     if (rq.kind == pfre_pkg::REQ_LIGHT) begin
                        s = (v * (int'(pfre_pkg::AMT_UNITY) - a) +
                             int'(pfre_pkg::CHAN_MAX) * a) >>> pfre_pkg::FRAC_BITS;
                        if (s > int'(pfre_pkg::CHAN_MAX)) s = int'(pfre_pkg::CHAN_MAX);
                     end else begin
                        s = (v * a) >>> pfre_pkg::FRAC_BITS;
                     end
                     shadow_palette[e][c*pfre_pkg::CHAN_W +: pfre_pkg::CHAN_W] =
                        pfre_pkg::CHAN_W'(s);
                  end
               end
            end
         end
         pfre_pkg::REQ_ROTATE: begin
            held = shadow_palette[rq.last];
            if (rq.first < rq.last) begin
               for (int i = int'(rq.last); i > int'(rq.first); i--) begin
                  shadow_palette[i] = shadow_palette[i-1];
               end
            end
            shadow_palette[rq.first] = held;
         end
         pfre_pkg::REQ_CLEAR: begin
            for (int e = 0; e < pfre_pkg::ENTRIES; e++) shadow_palette[e] = '0;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic add_request(input logic [pfre_pkg::REQ_W-1:0] kind,
                              input logic [pfre_pkg::IDX_W-1:0] first,
                              input logic [pfre_pkg::IDX_W-1:0] last,
                              input logic [pfre_pkg::AMT_W-1:0] amt);
      palette_request_type rq;
      rq.kind  = kind;
      rq.first = first;
      rq.last  = last;
      rq.red   = 8'($urandom_range(0, 255));
      rq.green = 8'($urandom_range(0, 255));
      rq.blue  = 8'($urandom_range(0, 255));
      rq.amt   = amt;
      rq.phase = build_phase;
      rq.drain = build_drain;
      build_drain = 1'b0;
      pending_requests.push_back(rq);
   endtask

   task automatic add_write(input logic [pfre_pkg::IDX_W-1:0] idx, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
      add_request(pfre_pkg::REQ_WRITE, idx, 8'($urandom_range(0, 255)),
                  6'($urandom_range(0, 63)));
      pending_requests[$].red   = red;
      pending_requests[$].green = green;
      pending_requests[$].blue  = blue;
      hot_indices.push_back(idx);
      if (hot_indices.size() > 16) void'(hot_indices.pop_front());
   endtask

   function automatic logic [pfre_pkg::IDX_W-1:0] any_index();
      return pfre_pkg::IDX_W'($urandom_range(0, pfre_pkg::ENTRIES - 1));
   endfunction

   function automatic logic [pfre_pkg::IDX_W-1:0] read_index();
      if (hot_indices.size() != 0 && $urandom_range(0, 1) == 0)
         return hot_indices[$urandom_range(0, hot_indices.size() - 1)];
      return any_index();
   endfunction

   task automatic build_directed();
      add_request(pfre_pkg::REQ_CLEAR, any_index(), any_index(), 6'd0);
      add_write(8'd0, 8'hFF, 8'h00, 8'hC0);
      add_write(pfre_pkg::LAST_IDX, 8'h00, 8'hFF, 8'h3F);
      add_write(8'd1, 8'h2A, 8'h15, 8'h3F);
      add_request(pfre_pkg::REQ_READ, 8'd0, any_index(), 6'd0);
      add_request(pfre_pkg::REQ_READ, pfre_pkg::LAST_IDX, any_index(), 6'd0);
      add_request(pfre_pkg::REQ_READ, 8'd2, any_index(), 6'd0);
      add_request(pfre_pkg::REQ_FADE, any_index(), any_index(), 6'd31);
      add_request(pfre_pkg::REQ_FADE, any_index(), any_index(), 6'd32);
      add_request(pfre_pkg::REQ_FADE, any_index(), any_index(), 6'd63);
      add_request(pfre_pkg::REQ_READ, 8'd0, any_index(), 6'd0);
      add_request(pfre_pkg::REQ_LIGHT, any_index(), any_index(), 6'd0);
      add_request(pfre_pkg::REQ_LIGHT, any_index(), any_index(), 6'd12);
      add_request(pfre_pkg::REQ_READ, 8'd1, any_index(), 6'd0);
      add_write(8'd2, 8'h01, 8'h3E, 8'h20);
      add_write(8'd3, 8'h10, 8'h20, 8'h30);
      add_request(pfre_pkg::REQ_ROTATE, 8'd0, 8'd3, 6'd0);
      add_request(pfre_pkg::REQ_READ, 8'd0, any_index(), 6'd0);
      add_request(pfre_pkg::REQ_ROTATE, 8'd5, 8'd2, 6'd0);
      add_request(pfre_pkg::REQ_ROTATE, 8'd7, 8'd7, 6'd0);
      add_request(pfre_pkg::REQ_ROTATE, 8'd0, pfre_pkg::LAST_IDX, 6'd0);
      add_request(pfre_pkg::REQ_READ, 8'd5, any_index(), 6'd0);
      add_request(pfre_pkg::REQ_FADE, any_index(), any_index(), 6'd0);
      add_request(pfre_pkg::REQ_LIGHT, any_index(), any_index(), 6'd32);
      add_request(pfre_pkg::REQ_LIGHT, any_index(), any_index(), 6'd63);
      add_request(REQ_SPARE_LO, any_index(), any_index(), 6'd0);
      add_request(REQ_SPARE_HI, any_index(), any_index(), 6'd0);
      add_request(pfre_pkg::REQ_READ, 8'd9, any_index(), 6'd0);
   endtask

   task automatic build_random();
      int counted;
      int pick;
      int span;
      logic [pfre_pkg::IDX_W-1:0] idx;
      logic [pfre_pkg::IDX_W-1:0] tail;
      logic [pfre_pkg::AMT_W-1:0] strength;
      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         if (2'(counted * 3 / RANDOM_REQUESTS) != build_phase) begin
            build_phase = 2'(counted * 3 / RANDOM_REQUESTS);
            build_drain = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 34) begin
            idx = any_index();
            add_write(idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) begin
               add_request(pfre_pkg::REQ_READ, idx, any_index(),
                           6'($urandom_range(0, 63)));
               counted++;
            end
         end else if (pick < 64) begin
            add_request(pfre_pkg::REQ_READ, read_index(), any_index(),
                        6'($urandom_range(0, 63)));
         end else if (pick < 70) begin
            strength = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(20, 31))
                                                   : 6'($urandom_range(0, 63));
            add_request(pfre_pkg::REQ_FADE, any_index(), any_index(), strength);
         end else if (pick < 76) begin
            strength = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 8))
                                                   : 6'($urandom_range(0, 63));
            add_request(pfre_pkg::REQ_LIGHT, any_index(), any_index(), strength);
         end else if (pick < 90) begin
            idx  = any_index();
            span = $urandom_range(0, 99);
            if (span < 70)
               tail = (int'(idx) + 12 > pfre_pkg::ENTRIES - 1) ?
                      pfre_pkg::LAST_IDX :
                      pfre_pkg::IDX_W'(idx + $urandom_range(1, 12));
            else if (span < 80)
               tail = idx;
            else if (span < 95)
               tail = any_index();
            else begin
               idx  = '0;
               tail = pfre_pkg::LAST_IDX;
            end
            add_request(pfre_pkg::REQ_ROTATE, idx, tail, 6'($urandom_range(0, 63)));
         end else if (pick < 97) begin
            add_request(pfre_pkg::REQ_CLEAR, any_index(), any_index(),
                        6'($urandom_range(0, 63)));
         end else begin
            add_request(($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI,
                        any_index(), any_index(), 6'($urandom_range(0, 63)));
            counted--;
         end
         counted++;
      end
   endtask

   always @(posedge clock) begin
      palette_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) apply_palette_request(live_req);
         if (pending_requests.size() != 0 &&
             !(pending_requests[0].drain && expected_colors.size() != 0) &&
             $urandom_range(0, 99) >= send_idle_pct(pending_requests[0].phase)) begin
            next_req = pending_requests.pop_front();
            live_req    <= next_req;
            drive_phase <= next_req.phase;
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_channel(input string name, input logic [pfre_pkg::OUT_W-1:0] want,
                                input logic [pfre_pkg::OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      scaled_color_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               $error("unexpected read result: red %0d, green %0d, blue %0d",
                      rsp_red_out, rsp_green_out, rsp_blue_out);
               fail_count++;
            end else begin
               want = expected_colors.pop_front();
               check_channel("rsp_red_out", want.red, rsp_red_out);
               check_channel("rsp_green_out", want.green, rsp_green_out);
               check_channel("rsp_blue_out", want.blue, rsp_blue_out);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct(drive_phase));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("palette_fade_rotate_engine_core test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      build_directed();
      build_random();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_colors.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_colors.size() != 0) begin
         $error("%0d read results never arrived", expected_colors.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("palette_fade_rotate_engine_core test passed");
      end else begin
         $display("palette_fade_rotate_engine_core test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pfre_pkg.sv
rtl/pfre_color_unit.sv
rtl/pfre_palette_ram.sv
rtl/palette_fade_rotate_engine_core.sv
verif/palette_fade_rotate_engine_core_tb.sv
